@@ hdl/scalar_kalman_filter_macros.svh @@
// Assertion macros shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge, switched off while reset is asserted.
`define SKF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define SKF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKF_ASSERT(lbl, clk, rstn, prop, msg)
`define SKF_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/skf_pkg.sv @@
// Shared types and constants of the scalar Kalman filter.
`timescale 1ns / 1ps

package skf_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MEAS_NOISE = 2'd0,
    REG_PROC_NOISE = 2'd1,
    REG_INIT_ERR   = 2'd2
  } skf_reg_e;

  localparam int unsigned CFG_INDEX_WIDTH = 2;

  // register reset values, Q16.16 literals
  localparam logic [63:0] RESET_MEAS_NOISE = 64'd131072;
  localparam logic [63:0] RESET_PROC_NOISE = 64'd66;
  localparam logic [63:0] RESET_INIT_ERR   = 64'd131072;

  // shared unit operations
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } skf_op_e;

  typedef struct packed {
    logic    start;
    skf_op_e op;
  } skf_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } skf_status_t;

endpackage

@@ hdl/skf_iter_unit.sv @@
// Shared shift-and-add unit: MSB-first multiply or restoring divide, one bit a cycle.
`timescale 1ns / 1ps

module skf_iter_unit #(
  parameter int unsigned DATA_WIDTH  = 32,
  parameter int unsigned MPLR_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  skf_pkg::skf_cmd_t          cmd_i,
  input  logic [COUNT_WIDTH-1:0]     count_i,
  input  logic [DATA_WIDTH:0]        opnd_i,      // multiplicand or divisor
  input  logic [MPLR_WIDTH-1:0]      mplr_i,      // multiplier, MSB aligned
  input  logic [DATA_WIDTH-1:0]      acc_init_i,  // dividend
  output skf_pkg::skf_status_t       status_o,
  output logic [DATA_WIDTH+MPLR_WIDTH-1:0] acc_o,
  output logic [MPLR_WIDTH-1:0]      mplr_o
);

  localparam int unsigned PW = DATA_WIDTH + MPLR_WIDTH;

  logic                   busy_q;
  logic                   done_q;
  logic [COUNT_WIDTH-1:0] count_q;
  skf_pkg::skf_op_e       op_q;
  logic [PW-1:0]          acc_q, acc_d;
  logic [MPLR_WIDTH-1:0]  mplr_q, mplr_d;
  logic [DATA_WIDTH:0]    opnd_q;

  logic [PW-1:0] add_x;
  logic [PW-1:0] add_y;
  logic          add_cin;
  logic [PW:0]   add_sum;

  // one adder serves both operations; for divide it subtracts the divisor
  always_comb begin
    add_x   = {acc_q[PW-2:0], 1'b0};
    add_y   = '0;
    add_cin = 1'b0;
    acc_d   = acc_q;
    mplr_d  = mplr_q;
    case (op_q)
      skf_pkg::OP_MUL: begin
        add_y  = mplr_q[MPLR_WIDTH-1] ? PW'(opnd_q) : '0;
        acc_d  = add_sum[PW-1:0];
        mplr_d = {mplr_q[MPLR_WIDTH-2:0], 1'b0};
      end
      skf_pkg::OP_DIV: begin
        add_y   = ~PW'(opnd_q);
        add_cin = 1'b1;
        acc_d   = add_sum[PW] ? add_sum[PW-1:0] : add_x;
        mplr_d  = {mplr_q[MPLR_WIDTH-2:0], add_sum[PW]};
      end
      default: begin
        acc_d  = acc_q;
        mplr_d = mplr_q;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{PW{1'b0}}, add_cin};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
      op_q    <= skf_pkg::OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q  <= 1'b1;
        count_q <= count_i;
        op_q    <= cmd_i.op;
      end else if (busy_q) begin
        count_q <= count_q - COUNT_WIDTH'(1);
        if (count_q == COUNT_WIDTH'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      opnd_q <= opnd_i;
      if (cmd_i.op == skf_pkg::OP_DIV) begin
        acc_q  <= PW'(acc_init_i);
        mplr_q <= '0;
      end else begin
        acc_q  <= '0;
        mplr_q <= mplr_i;
      end
    end else if (busy_q) begin
      acc_q  <= acc_d;
      mplr_q <= mplr_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign acc_o         = acc_q;
  assign mplr_o        = mplr_q;

endmodule

@@ hdl/scalar_kalman_filter.sv @@
// Scalar Kalman filter top level: sequencer, state and configuration registers.
// Items pass one at a time through the bit-serial shared unit (divide, then
// three multiplies); the divide is skipped when P + R or R is zero.
// Reset: estimate clears to zero, registers and estimate error take reset values.
`timescale 1ns / 1ps

`include "scalar_kalman_filter_macros.svh"

module scalar_kalman_filter #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [skf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index_i,
  input  logic [DATA_WIDTH-1:0]                  cfg_data_i,
  // measurement channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]           measurement_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [DATA_WIDTH-1:0]           filtered_estimate_o,
  output logic [FRAC_BITS:0]                     gain_used_o
);

  // multiplier register must hold a full data word or a gain with its unit bit
  localparam int unsigned BW = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;
  localparam int unsigned PW = DATA_WIDTH + BW;
  localparam int unsigned CW = $clog2(BW + 1);
  localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN_GO,
    S_GAIN_WAIT,
    S_STEP_GO,
    S_STEP_WAIT,
    S_PERR_GO,
    S_PERR_WAIT,
    S_QERR_GO,
    S_QERR_WAIT,
    S_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [DATA_WIDTH-1:0] meas_noise_q;
  logic [DATA_WIDTH-1:0] proc_noise_q;
  logic [DATA_WIDTH-1:0] init_err_q;

  // filter state
  logic [DATA_WIDTH-1:0] est_q;
  logic [DATA_WIDTH-1:0] err_q;

  // per-item working registers
  logic [DATA_WIDTH-1:0] mag_q;     // |z - x|
  logic                  neg_q;     // z < x
  logic [DATA_WIDTH:0]   den_q;     // P + R
  logic [FRAC_BITS:0]    gain_q;
  logic [DATA_WIDTH-1:0] step_q;
  logic [DATA_WIDTH-1:0] t1_q;      // (1 - k) * P term

  // result register
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_est_q;
  logic [FRAC_BITS:0]    out_gain_q;

  // shared unit connection
  skf_pkg::skf_cmd_t     cmd;
  skf_pkg::skf_status_t  status;
  logic [CW-1:0]         unit_count;
  logic [DATA_WIDTH:0]   unit_opnd;
  logic [BW-1:0]         unit_mplr;
  logic [PW-1:0]         unit_acc;
  logic [BW-1:0]         unit_mplr_res;

  // combinational helpers
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH:0]   diff_abs;
  logic [DATA_WIDTH-1:0] prod_sat;   // product >> FRAC_BITS, saturated
  logic [DATA_WIDTH-1:0] est_next;
  logic [DATA_WIDTH:0]   err_sum;
  logic [DATA_WIDTH-1:0] err_next;
  logic                  in_xfer;
  logic                  out_free;
  logic                  unit_waiting;
  logic [FRAC_BITS:0]    one_minus_gain;

  assign in_xfer  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer sits in one of the states that wait for the shared unit
  assign unit_waiting = (state_q == S_GAIN_WAIT) || (state_q == S_STEP_WAIT) ||
                        (state_q == S_PERR_WAIT) || (state_q == S_QERR_WAIT);

  // innovation, one bit wider so it never wraps
  assign diff     = {measurement_i[DATA_WIDTH-1], measurement_i} - {est_q[DATA_WIDTH-1], est_q};
  assign diff_abs = diff[DATA_WIDTH] ? (~diff + (DATA_WIDTH+1)'(1)) : diff;

  assign prod_sat = (unit_acc[PW-1:FRAC_BITS+DATA_WIDTH] != '0) ? '1
                  : unit_acc[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];

  // step never exceeds |z - x|, so the new estimate stays between x and z
  assign est_next = neg_q ? (est_q - prod_sat) : (est_q + prod_sat);

  assign err_sum  = {1'b0, t1_q} + {1'b0, prod_sat};
  assign err_next = err_sum[DATA_WIDTH] ? '1 : err_sum[DATA_WIDTH-1:0];

  assign one_minus_gain = GAIN_ONE - gain_q;

  // unit commands, issued for one cycle from the *_GO states
  always_comb begin
    cmd.start  = 1'b0;
    cmd.op     = skf_pkg::OP_MUL;
    unit_count = '0;
    unit_opnd  = '0;
    unit_mplr  = '0;
    case (state_q)
      S_GAIN_GO: begin
        // zero denominator and zero noise are settled without dividing
        cmd.start  = (den_q != '0) && (meas_noise_q != '0);
        cmd.op     = skf_pkg::OP_DIV;
        unit_count = CW'(FRAC_BITS);
        unit_opnd  = den_q;
      end
      S_STEP_GO: begin
        cmd.start  = 1'b1;
        unit_count = CW'(FRAC_BITS + 1);
        unit_opnd  = {1'b0, mag_q};
        unit_mplr  = BW'(gain_q) << (BW - FRAC_BITS - 1);
      end
      S_PERR_GO: begin
        cmd.start  = 1'b1;
        unit_count = CW'(FRAC_BITS + 1);
        unit_opnd  = {1'b0, err_q};
        unit_mplr  = BW'(one_minus_gain) << (BW - FRAC_BITS - 1);
      end
      S_QERR_GO: begin
        cmd.start  = 1'b1;
        unit_count = CW'(DATA_WIDTH);
        unit_opnd  = {1'b0, step_q};
        unit_mplr  = BW'(proc_noise_q) << (BW - DATA_WIDTH);
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  skf_iter_unit #(
    .DATA_WIDTH  (DATA_WIDTH),
    .MPLR_WIDTH  (BW),
    .COUNT_WIDTH (CW)
  ) u_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .count_i    (unit_count),
    .opnd_i     (unit_opnd),
    .mplr_i     (unit_mplr),
    .acc_init_i (err_q),
    .status_o   (status),
    .acc_o      (unit_acc),
    .mplr_o     (unit_mplr_res)
  );

  // sequencer, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      meas_noise_q <= skf_pkg::RESET_MEAS_NOISE[DATA_WIDTH-1:0];
      proc_noise_q <= skf_pkg::RESET_PROC_NOISE[DATA_WIDTH-1:0];
      init_err_q   <= skf_pkg::RESET_INIT_ERR[DATA_WIDTH-1:0];
      est_q        <= '0;
      err_q        <= skf_pkg::RESET_INIT_ERR[DATA_WIDTH-1:0];
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          skf_pkg::REG_MEAS_NOISE: meas_noise_q <= cfg_data_i;
          skf_pkg::REG_PROC_NOISE: proc_noise_q <= cfg_data_i;
          skf_pkg::REG_INIT_ERR: begin
            init_err_q <= cfg_data_i;
            err_q      <= cfg_data_i;
          end
          default: begin
            init_err_q <= init_err_q;
          end
        endcase
      end

      // in S_DONE the valid flag is set below instead
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_GAIN_GO;
          end
        end
        S_GAIN_GO: begin
          state_q <= cmd.start ? S_GAIN_WAIT : S_STEP_GO;
        end
        S_GAIN_WAIT: begin
          if (status.done) begin
            state_q <= S_STEP_GO;
          end
        end
        S_STEP_GO: state_q <= S_STEP_WAIT;
        S_STEP_WAIT: begin
          if (status.done) begin
            est_q   <= est_next;
            state_q <= S_PERR_GO;
          end
        end
        S_PERR_GO: state_q <= S_PERR_WAIT;
        S_PERR_WAIT: begin
          if (status.done) begin
            state_q <= S_QERR_GO;
          end
        end
        S_QERR_GO: state_q <= S_QERR_WAIT;
        S_QERR_WAIT: begin
          if (status.done) begin
            err_q   <= err_next;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold here only while the previous result still waits
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mag_q <= diff_abs[DATA_WIDTH-1:0];
          neg_q <= diff[DATA_WIDTH];
          den_q <= {1'b0, err_q} + {1'b0, meas_noise_q};
        end
      end
      S_GAIN_GO: begin
        if (den_q == '0) begin
          gain_q <= '0;
        end else if (meas_noise_q == '0) begin
          gain_q <= GAIN_ONE;
        end
      end
      S_GAIN_WAIT: begin
        if (status.done) begin
          gain_q <= {1'b0, unit_mplr_res[FRAC_BITS-1:0]};
        end
      end
      S_STEP_WAIT: begin
        if (status.done) begin
          step_q <= prod_sat;
        end
      end
      S_PERR_WAIT: begin
        if (status.done) begin
          t1_q <= prod_sat;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_est_q  <= est_q;
          out_gain_q <= gain_q;
        end
      end
      default: begin
        t1_q <= t1_q;
      end
    endcase
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign filtered_estimate_o = out_est_q;
  assign gain_used_o         = out_gain_q;

  // the shared unit is never restarted mid-operation
  `SKF_ASSERT(a_start_idle_unit, clk_i, rst_ni, cmd.start |-> !status.busy, "unit restarted while busy")
  // completions only arrive where the sequencer waits for them
  `SKF_ASSERT(a_done_in_wait, clk_i, rst_ni, status.done |-> unit_waiting, "unit done outside a wait state")
  // a transfer in closes the input until the item is finished
  `SKF_ASSERT(a_stall_after_xfer, clk_i, rst_ni, in_xfer |=> in_stall_o, "input open after transfer")
  // gain never exceeds one
  `SKF_ASSERT(a_gain_bound, clk_i, rst_ni, out_valid_o |-> (gain_used_o <= GAIN_ONE), "gain above one")
  // no result is offered while in reset
  `SKF_ASSERT_NR(a_reset_no_valid, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

@@ tb/tb_scalar_kalman_filter.sv @@
// Self-checking testbench of the scalar Kalman filter: directed and random samples.
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;

  localparam int unsigned DW = 32;
  localparam int unsigned FW = 16;
  // allowance for one filter step, used when waiting for the block to settle
  localparam int unsigned STEP_LATENCY = 3 * FW + DW + 12;
  localparam int unsigned SETTLE_CYCLES = STEP_LATENCY + 16;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_SAMPLES = 50;

  // index 3 has no register behind it
  localparam logic [skf_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  localparam logic [95:0] GAIN_ONE = 96'd1 << FW;
  localparam logic [95:0] ERR_MAX  = (96'd1 << DW) - 96'd1;

  localparam logic [DW-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] SAMPLE_MIN = 32'h8000_0000;
  localparam logic [DW-1:0] NOISE_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_RUNS
  } stall_pattern_e;

  typedef struct {
    logic signed [DW-1:0] estimate;
    logic [FW:0]          gain;
  } filter_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic                                cfg_we    = 1'b0;
  logic [skf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [DW-1:0]                       cfg_data  = '0;

  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic signed [DW-1:0] measurement = '0;

  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic signed [DW-1:0] filtered_estimate;
  logic [FW:0]          gain_used;

  // filter state as predicted by the testbench
  logic [DW-1:0] meas_noise   = skf_pkg::RESET_MEAS_NOISE[DW-1:0];
  logic [DW-1:0] proc_noise   = skf_pkg::RESET_PROC_NOISE[DW-1:0];
  logic [DW-1:0] estimate_q   = '0;
  logic [DW-1:0] estimate_err = skf_pkg::RESET_INIT_ERR[DW-1:0];

  logic [DW-1:0]  samples_waiting[$];
  filter_result_t estimates_due[$];

  int unsigned error_count    = 0;
  int unsigned samples_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned reg_writes     = 0;
  int unsigned drain_pauses   = 0;
  longint unsigned cycle_count = 0;

  scalar_kalman_filter #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FW)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .measurement_i      (measurement),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .filtered_estimate_o(filtered_estimate),
    .gain_used_o        (gain_used)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One filter step: gain, estimate move and error update, all at 96 bits so
  // nothing wraps before the explicit saturation.
  task automatic advance_filter(input logic [DW-1:0] z);
    longint         z_l, x_l, diff, step_l, x_next;
    logic [95:0]    p_w, mag, gain, step, t1, t2, total;
    filter_result_t res;
    z_l = {{(64-DW){z[DW-1]}}, z};
    x_l = {{(64-DW){estimate_q[DW-1]}}, estimate_q};
    p_w = 96'(estimate_err);
    if (p_w + 96'(meas_noise) == 96'd0) begin
      gain = '0;
    end else if (meas_noise == '0) begin
      gain = GAIN_ONE;
    end else begin
      gain = (p_w << FW) / (p_w + 96'(meas_noise));
    end
    diff = z_l - x_l;
    mag  = (diff < 0) ? 96'(-diff) : 96'(diff);
    step = (mag * gain) >> FW;
    if (step > mag) begin
      step = mag;
    end
    step_l = step[63:0];
    x_next = (diff < 0) ? x_l - step_l : x_l + step_l;
    // error: (1 - k) * P plus q times the size of the move
    t1 = ((GAIN_ONE - gain) * p_w) >> FW;
    t2 = (step * 96'(proc_noise)) >> FW;
    if (t1 > ERR_MAX) begin
      t1 = ERR_MAX;
    end
    if (t2 > ERR_MAX) begin
      t2 = ERR_MAX;
    end
    total = t1 + t2;
    if (total > ERR_MAX) begin
      total = ERR_MAX;
    end
    estimate_q   = x_next[DW-1:0];
    estimate_err = total[DW-1:0];
    res.estimate = x_next[DW-1:0];
    res.gain     = gain[FW:0];
    estimates_due.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps, and now and then a hold until
  // every outstanding estimate is back. Payload only moves when no stall holds it.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  logic        drain_hold = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        advance_filter(measurement);
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (drain_hold && estimates_due.size() == 0) begin
          drain_hold = 1'b0;
        end
        if (drain_hold || gap_left != 0 || samples_waiting.size() == 0) begin
          in_valid <= 1'b0;
          if (!drain_hold && gap_left != 0) begin
            gap_left--;
          end
        end else begin
          in_valid    <= 1'b1;
          measurement <= samples_waiting.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 8);
              default: gap_left = $urandom_range(1, 120);
            endcase
            // first burst end always waits for the pipeline to empty
            if (drain_pauses == 0 || $urandom_range(0, 7) == 0) begin
              drain_hold = 1'b1;
              drain_pauses++;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result transfer against the oldest prediction, and
  // stalls on a pattern (none, coin flips or runs) that is picked anew at random.
  // ---------------------------------------------------------------------------
  stall_pattern_e stall_pattern = STALL_NONE;
  int unsigned    pattern_left  = 0;
  int unsigned    run_left      = 0;
  logic           run_level     = 1'b0;

  always @(posedge clk_i) begin
    filter_result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (estimates_due.size() == 0) begin
          $error("unexpected result: filtered_estimate %h gain_used %h",
                 filtered_estimate, gain_used);
          error_count++;
        end else begin
          want = estimates_due.pop_front();
          if (filtered_estimate !== want.estimate) begin
            $error("filtered_estimate: expected %h, actual %h", want.estimate,
                   filtered_estimate);
            error_count++;
          end
          if (gain_used !== want.gain) begin
            $error("gain_used: expected %h, actual %h", want.gain, gain_used);
            error_count++;
          end
        end
      end
      if (pattern_left == 0) begin
        stall_pattern = stall_pattern_e'($urandom_range(0, 2));
        pattern_left  = $urandom_range(64, 256);
      end else begin
        pattern_left--;
      end
      case (stall_pattern)
        STALL_NONE: out_stall <= 1'b0;
        STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            run_left  = $urandom_range(1, 40);
            run_level = ~run_level;
          end else begin
            run_left--;
          end
          out_stall <= run_level;
        end
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("scalar_kalman_filter test failed");
      $finish;
    end
  end

  // Nothing queued, nothing in flight; then the block's own latency so it has
  // truly gone quiet before a register changes.
  task automatic wait_settled();
    while (samples_waiting.size() != 0 || in_valid || estimates_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [skf_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [DW-1:0] value);
    wait_settled();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      skf_pkg::REG_MEAS_NOISE: meas_noise = value;
      skf_pkg::REG_PROC_NOISE: proc_noise = value;
      skf_pkg::REG_INIT_ERR: begin
        // also reloads the running error
        estimate_err = value;
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  // noise settings: extremes, small typical values, anything at all
  function automatic logic [DW-1:0] pick_noise();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NOISE_MAX;
      2, 3:    return $urandom;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  // mostly a noisy sensor around a level, sometimes rails or raw junk
  function automatic logic [DW-1:0] pick_sample(input logic [DW-1:0] level,
                                                input int unsigned spread);
    case ($urandom_range(0, 19))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return NOISE_MAX;
      4, 5:    return $urandom;
      default: return level + $urandom_range(0, 2 * spread) - spread;
    endcase
  endfunction

  initial begin
    logic [DW-1:0] level;
    int unsigned   spread;
    // falling edge at time zero so the asynchronous reset takes hold at once
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, swings between the rails
    samples_waiting.push_back(SAMPLE_MAX);
    samples_waiting.push_back(SAMPLE_MIN);
    samples_waiting.push_back(SAMPLE_MAX);
    samples_waiting.push_back(NOISE_MAX);
    samples_waiting.push_back(32'd1);
    samples_waiting.push_back('0);

    // R and P both zero: zero denominator, gain zero
    write_reg(skf_pkg::REG_MEAS_NOISE, '0);
    write_reg(skf_pkg::REG_PROC_NOISE, '0);
    write_reg(skf_pkg::REG_INIT_ERR, '0);
    samples_waiting.push_back(32'h1234_5678);
    samples_waiting.push_back(SAMPLE_MIN);

    // R zero, P nonzero: gain exactly one, then zero once P has dropped to zero
    write_reg(skf_pkg::REG_INIT_ERR, 32'd1);
    samples_waiting.push_back(SAMPLE_MAX);
    samples_waiting.push_back(SAMPLE_MIN);

    // everything at its maximum: denominator beyond 32 bits, error saturates
    write_reg(skf_pkg::REG_MEAS_NOISE, NOISE_MAX);
    write_reg(skf_pkg::REG_PROC_NOISE, NOISE_MAX);
    write_reg(skf_pkg::REG_INIT_ERR, NOISE_MAX);
    samples_waiting.push_back(SAMPLE_MIN);
    samples_waiting.push_back(SAMPLE_MAX);
    samples_waiting.push_back(SAMPLE_MIN);

    // write to the empty index must change nothing
    write_reg(REG_UNUSED, $urandom);
    samples_waiting.push_back(32'h0001_0000);
    samples_waiting.push_back(32'hFFFF_0000);

    // tiny R, default Q, P of one
    write_reg(skf_pkg::REG_MEAS_NOISE, 32'd1);
    write_reg(skf_pkg::REG_PROC_NOISE, skf_pkg::RESET_PROC_NOISE[DW-1:0]);
    write_reg(skf_pkg::REG_INIT_ERR, 32'h0001_0000);
    samples_waiting.push_back(32'h0003_8000);
    samples_waiting.push_back(32'hFFFC_8000);

    // random phases, each with its own settings and signal level
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(0, 1) == 1) begin
        write_reg(skf_pkg::REG_MEAS_NOISE, pick_noise());
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(skf_pkg::REG_PROC_NOISE, pick_noise());
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(skf_pkg::REG_INIT_ERR, pick_noise());
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg(REG_UNUSED, $urandom);
      end
      level  = $urandom;
      spread = $urandom_range(1, 32'h0010_0000);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        samples_waiting.push_back(pick_sample(level, spread));
      end
    end

    wait_settled();
    if (estimates_due.size() != 0) begin
      $error("%0d estimates never arrived", estimates_due.size());
      error_count++;
    end
    $display("Run covered %0d samples and %0d results across %0d register writes,",
             samples_sent, results_seen, reg_writes);
    $display("with %0d pauses to drain the filter and %0d mismatches.",
             drain_pauses, error_count);
    if (error_count == 0) begin
      $display("scalar_kalman_filter test passed");
    end else begin
      $display("scalar_kalman_filter test failed");
    end
    $finish;
  end

endmodule
